// ===== hw/rtl/rsr_pkg.sv =====
// Shared types, constants and elaboration-time tables for the radio setting calculator.
`default_nettype none

package rsr_pkg;

  // Crystal and request limits
  localparam int CRYSTAL_HZ     = 32000000;
  localparam int MAX_PAYLOAD    = 64;
  localparam int MAX_SYNC_BYTES = 8;

  // Field widths
  localparam int CARRIER_W = 30;
  localparam int RATE_W    = 19;
  localparam int DEV_W     = 20;
  localparam int BW_W      = 20;
  localparam int MOD_W     = 3;
  localparam int PWR_W     = 6;
  localparam int SYNC_W    = 4;
  localparam int PAY_W     = 8;
  localparam int BR_W      = 16;
  localparam int FDEV_W    = 14;
  localparam int FRF_W     = 24;
  localparam int MODC_W    = 4;
  localparam int RXBW_W    = 7;
  localparam int BYTE_W    = 8;

  // Validity ranges
  localparam int CARRIER_MIN = 290000000;
  localparam int CARRIER_MAX = 1020000000;
  localparam int RATE_MAX    = 300000;
  localparam int PWR_MIN     = -18;
  localparam int PWR_MAX     = 13;
  localparam int PWR_OFS     = 18;

  // Defaults for zero requests
  localparam int DEF_RATE = 4800;
  localparam int DEF_DEV  = 5000;

  // Word limits
  localparam int BR_MAX   = 16'hFFFF;
  localparam int FDEV_MAX = 14'h3FFF;
  localparam int FRF_MAX  = 24'hFFFFFF;

  typedef enum logic [MOD_W-1:0] {
    MOD_NONE    = 3'd0,
    MOD_FSK     = 3'd1,
    MOD_GFSK    = 3'd2,
    MOD_MSK     = 3'd3,
    MOD_GMSK    = 3'd4,
    MOD_OOK     = 3'd5,
    MOD_LORA    = 3'd6,
    MOD_INVALID = 3'd7
  } mod_e;

  localparam logic [MODC_W-1:0] MODC_PLAIN  = 4'd0;
  localparam logic [MODC_W-1:0] MODC_SHAPED = 4'd1;
  localparam logic [MODC_W-1:0] MODC_OOK    = 4'd8;

  localparam logic [BYTE_W-1:0] PA_BASE    = 8'h80;
  localparam logic [BYTE_W-1:0] PKT_VAR    = 8'h80;
  localparam logic [BYTE_W-1:0] PKT_CRC    = 8'h10;
  localparam logic [BYTE_W-1:0] PKT_NODE   = 8'h02;
  localparam logic [BYTE_W-1:0] SYNC_ON    = 8'h80;
  localparam int                SYNC_SHIFT = 3;

  // Divider geometry
  localparam int STEP_SHIFT    = 19;
  localparam int CRY_W         = $clog2(CRYSTAL_HZ + 1);
  localparam int DIVD_W        = CARRIER_W + STEP_SHIFT + 1;
  localparam int DSR_W         = (CRY_W > RATE_W) ? CRY_W : RATE_W;
  localparam int STEPS_A       = DIVD_W - CRY_W + 1;
  localparam int STEPS_B       = CRY_W + 1;
  localparam int DIV_STEPS     = (STEPS_A > STEPS_B) ? STEPS_A : STEPS_B;
  localparam int STEPS_PER_STG = 4;
  localparam int NUM_DIV_STG   = (DIV_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam logic [DIVD_W-1:0] HALF_XTAL = DIVD_W'(CRYSTAL_HZ / 2);
  localparam logic [DIVD_W-1:0] XTAL_N    = DIVD_W'(CRYSTAL_HZ);

  localparam int NUM_LANES = 3;
  localparam int LANE_BR   = 0;
  localparam int LANE_FD   = 1;
  localparam int LANE_FRF  = 2;

  typedef struct packed {
    logic [DSR_W-1:0]     den;
    logic [DSR_W-1:0]     rem;
    logic [DIV_STEPS-1:0] lo;   // dividend bits still to shift in, quotient bits shifted in
  } div_lane_t;

  typedef div_lane_t [NUM_LANES-1:0] lanes_t;

  typedef struct packed {
    logic              ok;
    logic [MODC_W-1:0] modul;
    logic [RXBW_W-1:0] rx_bw;
    logic [BYTE_W-1:0] pa;
    logic [BYTE_W-1:0] pkt;
    logic [BYTE_W-1:0] sync;
    logic [BYTE_W-1:0] len;
  } side_t;

  typedef struct packed {
    side_t  side;
    lanes_t lanes;
  } pipe_data_t;

  // Receive bandwidth candidate tables
  localparam int NUM_BW      = 24;
  localparam int BW_CMP_W    = (CRY_W > BW_W) ? CRY_W : BW_W;
  localparam int BW_SHIFT_FSK = 2;
  localparam int BW_SHIFT_OOK = 3;
  localparam logic [RXBW_W-1:0] BW_CODE_BASE = 7'h40;
  localparam logic [RXBW_W-1:0] BW_DEF_CODE  = 7'h55;

  typedef logic [BW_CMP_W-1:0] bw_hz_arr_t [NUM_BW];
  typedef logic [RXBW_W-1:0]   bw_code_arr_t [NUM_BW];

  function automatic logic [BW_CMP_W-1:0] bw_raw_hz(input int idx, input int s);
    int q;
    q = CRYSTAL_HZ >> ((idx & 7) + s);
    case (idx >> 3)
      0:       q = q >> 4;
      1:       q = q / 20;
      default: q = q / 24;
    endcase
    return BW_CMP_W'(q);
  endfunction

  function automatic logic [RXBW_W-1:0] bw_raw_code(input int idx);
    return BW_CODE_BASE | RXBW_W'(((idx >> 3) << 3) | (idx & 7));
  endfunction

  // Stable ascending order: ties keep mantissa/exponent order
  function automatic int bw_rank(input int i, input int s);
    int r;
    r = 0;
    for (int j = 0; j < NUM_BW; j++) begin
      if ((bw_raw_hz(j, s) < bw_raw_hz(i, s)) ||
          ((bw_raw_hz(j, s) == bw_raw_hz(i, s)) && (j < i))) begin
        r++;
      end
    end
    return r;
  endfunction

  function automatic bw_hz_arr_t bw_hz_sorted(input int s);
    bw_hz_arr_t r;
    for (int i = 0; i < NUM_BW; i++) begin
      r[bw_rank(i, s)] = bw_raw_hz(i, s);
    end
    return r;
  endfunction

  function automatic bw_code_arr_t bw_code_sorted(input int s);
    bw_code_arr_t r;
    for (int i = 0; i < NUM_BW; i++) begin
      r[bw_rank(i, s)] = bw_raw_code(i);
    end
    return r;
  endfunction

  function automatic logic [RXBW_W-1:0] bw_max_code(input int s);
    logic [BW_CMP_W-1:0] best;
    logic [RXBW_W-1:0]   code;
    best = '0;
    code = BW_CODE_BASE;
    for (int i = 0; i < NUM_BW; i++) begin
      if (bw_raw_hz(i, s) > best) begin
        best = bw_raw_hz(i, s);
        code = bw_raw_code(i);
      end
    end
    return code;
  endfunction

  localparam bw_hz_arr_t   BW_HZ_FSK   = bw_hz_sorted(BW_SHIFT_FSK);
  localparam bw_hz_arr_t   BW_HZ_OOK   = bw_hz_sorted(BW_SHIFT_OOK);
  localparam bw_code_arr_t BW_CODE_FSK = bw_code_sorted(BW_SHIFT_FSK);
  localparam bw_code_arr_t BW_CODE_OOK = bw_code_sorted(BW_SHIFT_OOK);
  localparam logic [RXBW_W-1:0] BW_MAX_FSK = bw_max_code(BW_SHIFT_FSK);
  localparam logic [RXBW_W-1:0] BW_MAX_OOK = bw_max_code(BW_SHIFT_OOK);

endpackage

`default_nettype wire

// ===== hw/rtl/rsr_prep.sv =====
// Front stage: checks, small register codes, bandwidth pick and divider setup.
`default_nettype none

module rsr_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [rsr_pkg::CARRIER_W-1:0]       carrier_hz_i,
  input  logic [rsr_pkg::RATE_W-1:0]          bit_rate_i,
  input  logic [rsr_pkg::DEV_W-1:0]           deviation_i,
  input  logic [rsr_pkg::BW_W-1:0]            bandwidth_i,
  input  logic [rsr_pkg::MOD_W-1:0]           modulation_i,
  input  logic signed [rsr_pkg::PWR_W-1:0]    power_dbm_i,
  input  logic [rsr_pkg::SYNC_W-1:0]          sync_len_i,
  input  logic [rsr_pkg::PAY_W-1:0]           payload_len_i,
  input  logic                                variable_mode_i,
  input  logic                                crc_on_i,
  input  logic                                node_filter_i,
  output logic                                vld_o,
  output rsr_pkg::pipe_data_t                 data_o
);
  import rsr_pkg::*;

  function automatic div_lane_t lane_init(input logic [DIVD_W-1:0] num,
                                          input logic [DSR_W-1:0] den);
    div_lane_t l;
    l.den = den;
    l.rem = DSR_W'(num >> DIV_STEPS);
    l.lo  = num[DIV_STEPS-1:0];
    return l;
  endfunction

  logic [RATE_W-1:0]   rate_eff;
  logic [DEV_W-1:0]    dev_eff;
  logic [DIVD_W-1:0]   br_num;
  logic [DIVD_W-1:0]   fd_num;
  logic [DIVD_W-1:0]   frf_num;
  logic [BW_CMP_W-1:0] bw_x;
  logic [RXBW_W-1:0]   bw_code;
  logic                is_ook;
  logic                ok;
  pipe_data_t          data_d;
  pipe_data_t          data_q;
  logic                vld_q;

  assign rate_eff = (bit_rate_i == '0) ? RATE_W'(DEF_RATE) : bit_rate_i;
  assign dev_eff  = (deviation_i == '0) ? DEV_W'(DEF_DEV) : deviation_i;
  assign br_num   = XTAL_N + DIVD_W'(rate_eff >> 1);
  assign fd_num   = (DIVD_W'(dev_eff) << STEP_SHIFT) + HALF_XTAL;
  assign frf_num  = (DIVD_W'(carrier_hz_i) << STEP_SHIFT) + HALF_XTAL;
  assign is_ook   = (mod_e'(modulation_i) == MOD_OOK);
  assign bw_x     = BW_CMP_W'(bandwidth_i);

  // First sorted entry reaching the request, else widest; zero gives default
  always_comb begin
    bw_code = is_ook ? BW_MAX_OOK : BW_MAX_FSK;
    for (int i = NUM_BW - 1; i >= 0; i--) begin
      if (is_ook) begin
        if (BW_HZ_OOK[i] >= bw_x) bw_code = BW_CODE_OOK[i];
      end else begin
        if (BW_HZ_FSK[i] >= bw_x) bw_code = BW_CODE_FSK[i];
      end
    end
    if (bandwidth_i == '0) bw_code = BW_DEF_CODE;
  end

  always_comb begin
    ok = 1'b1;
    if (!(carrier_hz_i inside {[CARRIER_MIN:CARRIER_MAX]})) ok = 1'b0;
    if (!(bit_rate_i inside {[1:RATE_MAX]})) ok = 1'b0;
    if (sync_len_i > SYNC_W'(MAX_SYNC_BYTES)) ok = 1'b0;
    if (payload_len_i > PAY_W'(MAX_PAYLOAD)) ok = 1'b0;
    if ((power_dbm_i < PWR_MIN) || (power_dbm_i > PWR_MAX)) ok = 1'b0;
    if ((payload_len_i == '0) && (variable_mode_i || crc_on_i || node_filter_i)) ok = 1'b0;
    if (!(modulation_i inside {MOD_FSK, MOD_GFSK, MOD_MSK, MOD_GMSK, MOD_OOK})) ok = 1'b0;
  end

  always_comb begin
    data_d.side.ok = ok;
    case (mod_e'(modulation_i))
      MOD_GFSK, MOD_GMSK: data_d.side.modul = MODC_SHAPED;
      MOD_OOK:            data_d.side.modul = MODC_OOK;
      default:            data_d.side.modul = MODC_PLAIN;
    endcase
    data_d.side.rx_bw = bw_code;
    data_d.side.pa    = PA_BASE | BYTE_W'(5'(power_dbm_i[4:0] + 5'(PWR_OFS)));
    data_d.side.pkt   = (variable_mode_i ? PKT_VAR : '0) | (crc_on_i ? PKT_CRC : '0) |
                        (node_filter_i ? PKT_NODE : '0);
    data_d.side.sync  = (sync_len_i == '0) ? '0 :
                        (SYNC_ON | (BYTE_W'(SYNC_W'(sync_len_i - 1'b1)) << SYNC_SHIFT));
    data_d.side.len   = payload_len_i + PAY_W'(node_filter_i);
    data_d.lanes[LANE_BR]  = lane_init(br_num, DSR_W'(rate_eff));
    data_d.lanes[LANE_FD]  = lane_init(fd_num, DSR_W'(CRYSTAL_HZ));
    data_d.lanes[LANE_FRF] = lane_init(frf_num, DSR_W'(CRYSTAL_HZ));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rsr_div.sv =====
// Pipelined restoring divider: three lanes, a few quotient bits per stage.
`default_nettype none

module rsr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  rsr_pkg::pipe_data_t data_i,
  output logic                vld_o,
  output rsr_pkg::pipe_data_t data_o
);
  import rsr_pkg::*;

  function automatic div_lane_t div_step(input div_lane_t a);
    logic [DSR_W:0] t;
    div_lane_t      r;
    r = a;
    t = {a.rem, a.lo[DIV_STEPS-1]};
    if (t >= {1'b0, a.den}) begin
      r.rem = DSR_W'(t - {1'b0, a.den});
      r.lo  = {a.lo[DIV_STEPS-2:0], 1'b1};
    end else begin
      r.rem = t[DSR_W-1:0];
      r.lo  = {a.lo[DIV_STEPS-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [NUM_DIV_STG:0] vld;
  pipe_data_t           data [NUM_DIV_STG+1];

  assign vld[0]  = vld_i;
  assign data[0] = data_i;

  for (genvar k = 0; k < NUM_DIV_STG; k++) begin : g_stg
    pipe_data_t nxt;
    pipe_data_t data_q;
    logic       vld_q;

    always_comb begin
      nxt = data[k];
      for (int l = 0; l < NUM_LANES; l++) begin
        for (int j = 0; j < STEPS_PER_STG; j++) begin
          // last stage may carry fewer steps
          if (k * STEPS_PER_STG + j < DIV_STEPS) begin
            nxt.lanes[l] = div_step(nxt.lanes[l]);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        data_q <= nxt;
      end
    end

    assign vld[k+1]  = vld_q;
    assign data[k+1] = data_q;
  end

  assign vld_o  = vld[NUM_DIV_STG];
  assign data_o = data[NUM_DIV_STG];

endmodule

`default_nettype wire

// ===== hw/rtl/radio_setting_register_calc_unit.sv =====
// Top level of the radio setting calculator: front stage, divider pipeline, output register.
//
// One request enters on the input channel (valid_i / stall_o plus one port per
// field) and one result leaves on the output channel (valid_o / stall_i).
// A transaction happens at a rising edge with valid high and stall low.
// The path is nine register stages: a front stage for range checks and the
// small codes, seven divider stages that resolve four quotient bits each (two
// in the last one) of three parallel restoring divisions (bit rate, deviation,
// carrier), and the output register that also applies the clamps. A new request
// can be taken in every cycle unless the receiver stalls a held result, so
// throughput is one transaction per clock outside such stalls.
// The whole pipeline moves together. It holds only while a result sits in the
// output register and the receiver stalls; stall_o is high exactly then, and
// nothing inside is lost or repeated.
// Reset (rst_ni low, asynchronous) empties every stage; no result is pending
// afterwards. The block has no state that carries from one request to the next.
`default_nettype none

module radio_setting_register_calc_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  logic [rsr_pkg::CARRIER_W-1:0]    carrier_hz_i,
  input  logic [rsr_pkg::RATE_W-1:0]       bit_rate_i,
  input  logic [rsr_pkg::DEV_W-1:0]        deviation_i,
  input  logic [rsr_pkg::BW_W-1:0]         bandwidth_i,
  input  logic [rsr_pkg::MOD_W-1:0]        modulation_i,
  input  logic signed [rsr_pkg::PWR_W-1:0] power_dbm_i,
  input  logic [rsr_pkg::SYNC_W-1:0]       sync_len_i,
  input  logic [rsr_pkg::PAY_W-1:0]        payload_len_i,
  input  logic                             variable_mode_i,
  input  logic                             crc_on_i,
  input  logic                             node_filter_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic                             valid_res_o,
  output logic [rsr_pkg::BR_W-1:0]         bitrate_word_o,
  output logic [rsr_pkg::FDEV_W-1:0]       fdev_word_o,
  output logic [rsr_pkg::FRF_W-1:0]        frf_word_o,
  output logic [rsr_pkg::MODC_W-1:0]       modul_code_o,
  output logic [rsr_pkg::RXBW_W-1:0]       rx_bw_code_o,
  output logic [rsr_pkg::BYTE_W-1:0]       pa_code_o,
  output logic [rsr_pkg::BYTE_W-1:0]       pkt_config_o,
  output logic [rsr_pkg::BYTE_W-1:0]       sync_code_o,
  output logic [rsr_pkg::BYTE_W-1:0]       length_code_o
);
  import rsr_pkg::*;

  logic                 en;
  logic                 prep_vld;
  pipe_data_t           prep_data;
  logic                 div_vld;
  pipe_data_t           div_data;
  logic [DIV_STEPS-1:0] br_q_raw;
  logic [DIV_STEPS-1:0] fd_q_raw;
  logic [DIV_STEPS-1:0] frf_q_raw;

  logic                 out_vld_q;
  side_t                side_q;
  logic [BR_W-1:0]      bitrate_word_d, bitrate_word_q;
  logic [FDEV_W-1:0]    fdev_word_d, fdev_word_q;
  logic [FRF_W-1:0]     frf_word_d, frf_word_q;

  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;

  rsr_prep u_prep (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .vld_i           (valid_i),
    .carrier_hz_i    (carrier_hz_i),
    .bit_rate_i      (bit_rate_i),
    .deviation_i     (deviation_i),
    .bandwidth_i     (bandwidth_i),
    .modulation_i    (modulation_i),
    .power_dbm_i     (power_dbm_i),
    .sync_len_i      (sync_len_i),
    .payload_len_i   (payload_len_i),
    .variable_mode_i (variable_mode_i),
    .crc_on_i        (crc_on_i),
    .node_filter_i   (node_filter_i),
    .vld_o           (prep_vld),
    .data_o          (prep_data)
  );

  rsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (prep_vld),
    .data_i (prep_data),
    .vld_o  (div_vld),
    .data_o (div_data)
  );

  assign br_q_raw  = div_data.lanes[LANE_BR].lo;
  assign fd_q_raw  = div_data.lanes[LANE_FD].lo;
  assign frf_q_raw = div_data.lanes[LANE_FRF].lo;

  always_comb begin
    if (br_q_raw == '0) begin
      bitrate_word_d = BR_W'(1);
    end else if (br_q_raw > DIV_STEPS'(BR_MAX)) begin
      bitrate_word_d = BR_W'(BR_MAX);
    end else begin
      bitrate_word_d = br_q_raw[BR_W-1:0];
    end
    fdev_word_d = (fd_q_raw > DIV_STEPS'(FDEV_MAX)) ? FDEV_W'(FDEV_MAX) : fd_q_raw[FDEV_W-1:0];
    frf_word_d  = (frf_q_raw > DIV_STEPS'(FRF_MAX)) ? FRF_W'(FRF_MAX) : frf_q_raw[FRF_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q         <= div_data.side;
      bitrate_word_q <= bitrate_word_d;
      fdev_word_q    <= fdev_word_d;
      frf_word_q     <= frf_word_d;
    end
  end

  assign valid_o        = out_vld_q;
  assign valid_res_o    = side_q.ok;
  assign bitrate_word_o = bitrate_word_q;
  assign fdev_word_o    = fdev_word_q;
  assign frf_word_o     = frf_word_q;
  assign modul_code_o   = side_q.modul;
  assign rx_bw_code_o   = side_q.rx_bw;
  assign pa_code_o      = side_q.pa;
  assign pkt_config_o   = side_q.pkt;
  assign sync_code_o    = side_q.sync;
  assign length_code_o  = side_q.len;

endmodule

`default_nettype wire

// ===== verif/radio_setting_register_calc_unit_tb.sv =====
// Self-checking testbench for the radio setting register calculator.
import rsr_pkg::*;

typedef struct packed {
  logic [CARRIER_W-1:0] carrier;
  logic [RATE_W-1:0]    rate;
  logic [DEV_W-1:0]     dev;
  logic [BW_W-1:0]      bw;
  mod_e                 mod;
  logic [PWR_W-1:0]     power;
  logic [SYNC_W-1:0]    sync;
  logic [PAY_W-1:0]     pay;
  logic                 var_len;
  logic                 crc;
  logic                 node;
} setting_req_t;

typedef struct packed {
  logic              ok;
  logic [BR_W-1:0]   bitrate;
  logic [FDEV_W-1:0] fdev;
  logic [FRF_W-1:0]  frf;
  logic [MODC_W-1:0] modul;
  logic [RXBW_W-1:0] rx_bw;
  logic [BYTE_W-1:0] pa;
  logic [BYTE_W-1:0] pkt;
  logic [BYTE_W-1:0] sync;
  logic [BYTE_W-1:0] len;
} reg_words_t;

class reg_word_board;
  reg_words_t words_due[$];
  int         mismatches;
  int         results_seen;

  function new();
    mismatches   = 0;
    results_seen = 0;
  endfunction

  // value * 2^19 / crystal, rounded
  static function longint unsigned synth_steps(longint unsigned hz);
    return ((hz << STEP_SHIFT) + longint'(CRYSTAL_HZ / 2)) / longint'(CRYSTAL_HZ);
  endfunction

  // narrowest bandwidth code at or above the request, else the widest one; zero gives the default code
  static function logic [RXBW_W-1:0] pick_bw_code(logic [BW_W-1:0] bw, bit ook);
    longint unsigned act, best_hz, top_hz;
    logic [RXBW_W-1:0] best, top, code;
    bit hit;
    if (bw == '0) return BW_DEF_CODE;
    best_hz = 0;
    top_hz  = 0;
    best    = BW_DEF_CODE;
    top     = BW_CODE_BASE;
    hit     = 1'b0;
    for (int m = 0; m < 3; m++) begin
      for (int e = 0; e < 8; e++) begin
        act  = longint'(CRYSTAL_HZ) /
               (longint'(16 + 4 * m) << (e + (ook ? BW_SHIFT_OOK : BW_SHIFT_FSK)));
        code = BW_CODE_BASE | RXBW_W'(m * 8 + e);
        if (act > top_hz) begin
          top_hz = act;
          top    = code;
        end
        if (act >= bw && (!hit || act < best_hz)) begin
          hit     = 1'b1;
          best_hz = act;
          best    = code;
        end
      end
    end
    return hit ? best : top;
  endfunction

  static function reg_words_t predict_words(setting_req_t r);
    reg_words_t w;
    longint unsigned rate, dev, q;
    int pwr;
    pwr = $signed(r.power);
    w.ok = (r.carrier >= CARRIER_MIN) && (r.carrier <= CARRIER_MAX) &&
           (r.rate != '0) && (r.rate <= RATE_MAX) &&
           (r.sync <= MAX_SYNC_BYTES) && (r.pay <= MAX_PAYLOAD) &&
           (pwr >= PWR_MIN) && (pwr <= PWR_MAX) &&
           !(r.pay == '0 && (r.var_len || r.crc || r.node)) &&
           (r.mod >= MOD_FSK) && (r.mod <= MOD_OOK);

    rate = (r.rate == '0) ? longint'(DEF_RATE) : longint'(r.rate);
    q = (longint'(CRYSTAL_HZ) + rate / 2) / rate;
    if (q == 0) q = 1;
    if (q > BR_MAX) q = BR_MAX;
    w.bitrate = BR_W'(q);

    dev = (r.dev == '0) ? longint'(DEF_DEV) : longint'(r.dev);
    q = synth_steps(dev);
    if (q > FDEV_MAX) q = FDEV_MAX;
    w.fdev = FDEV_W'(q);

    q = synth_steps(longint'(r.carrier));
    if (q > FRF_MAX) q = FRF_MAX;
    w.frf = FRF_W'(q);

    if (r.mod == MOD_GFSK || r.mod == MOD_GMSK) w.modul = MODC_SHAPED;
    else if (r.mod == MOD_OOK) w.modul = MODC_OOK;
    else w.modul = MODC_PLAIN;

    w.rx_bw = pick_bw_code(r.bw, r.mod == MOD_OOK);
    w.pa    = PA_BASE | BYTE_W'((r.power + PWR_OFS) & 5'h1F);
    w.pkt   = (r.var_len ? PKT_VAR : 8'h00) | (r.crc ? PKT_CRC : 8'h00) |
              (r.node ? PKT_NODE : 8'h00);
    w.sync  = (r.sync == '0) ? 8'h00 : (SYNC_ON | BYTE_W'((r.sync - 1) << SYNC_SHIFT));
    w.len   = BYTE_W'(r.pay + r.node);
    return w;
  endfunction

  function void note_request(setting_req_t r);
    words_due.push_back(predict_words(r));
  endfunction

  function void flag_miss(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
               $time, results_seen, what, want, got);
  endfunction

  function void check_result(reg_words_t got);
    reg_words_t want;
    results_seen++;
    if (words_due.size() == 0) begin
      flag_miss("transaction with nothing pending", 0, got.bitrate);
      return;
    end
    want = words_due.pop_front();
    if (got.ok != want.ok)           flag_miss("valid_res", want.ok, got.ok);
    if (got.bitrate != want.bitrate) flag_miss("bitrate_word", want.bitrate, got.bitrate);
    if (got.fdev != want.fdev)       flag_miss("fdev_word", want.fdev, got.fdev);
    if (got.frf != want.frf)         flag_miss("frf_word", want.frf, got.frf);
    if (got.modul != want.modul)     flag_miss("modul_code", want.modul, got.modul);
    if (got.rx_bw != want.rx_bw)     flag_miss("rx_bw_code", want.rx_bw, got.rx_bw);
    if (got.pa != want.pa)           flag_miss("pa_code", want.pa, got.pa);
    if (got.pkt != want.pkt)         flag_miss("pkt_config", want.pkt, got.pkt);
    if (got.sync != want.sync)       flag_miss("sync_code", want.sync, got.sync);
    if (got.len != want.len)         flag_miss("length_code", want.len, got.len);
  endfunction
endclass

module radio_setting_register_calc_unit_tb;

  localparam int CLK_PERIOD   = 10;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_LEN     = 60;
  localparam int IDLE_PCT     = 18;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 valid_i         = 1'b0;
  logic                 stall_o;
  logic [CARRIER_W-1:0] carrier_hz_i    = '0;
  logic [RATE_W-1:0]    bit_rate_i      = '0;
  logic [DEV_W-1:0]     deviation_i     = '0;
  logic [BW_W-1:0]      bandwidth_i     = '0;
  logic [MOD_W-1:0]     modulation_i    = '0;
  logic signed [PWR_W-1:0] power_dbm_i  = '0;
  logic [SYNC_W-1:0]    sync_len_i      = '0;
  logic [PAY_W-1:0]     payload_len_i   = '0;
  logic                 variable_mode_i = 1'b0;
  logic                 crc_on_i        = 1'b0;
  logic                 node_filter_i   = 1'b0;
  logic                 valid_o;
  logic                 stall_i         = 1'b0;
  logic                 valid_res_o;
  logic [BR_W-1:0]      bitrate_word_o;
  logic [FDEV_W-1:0]    fdev_word_o;
  logic [FRF_W-1:0]     frf_word_o;
  logic [MODC_W-1:0]    modul_code_o;
  logic [RXBW_W-1:0]    rx_bw_code_o;
  logic [BYTE_W-1:0]    pa_code_o;
  logic [BYTE_W-1:0]    pkt_config_o;
  logic [BYTE_W-1:0]    sync_code_o;
  logic [BYTE_W-1:0]    length_code_o;

  reg_word_board book;
  int  tx_idle_pct  = IDLE_PCT;
  int  rx_stall_pct = IDLE_PCT;
  logic hold_go     = 1'b0;
  logic hold_done   = 1'b0;
  int  hold_left    = 0;

  radio_setting_register_calc_unit dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      stall_i   <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_done) begin
      stall_i   <= 1'b1;
      hold_left <= HOLD_LEN - 1;
      hold_done <= hold_go;
    end else begin
      stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o)
      book.note_request('{carrier: carrier_hz_i, rate: bit_rate_i, dev: deviation_i,
                          bw: bandwidth_i, mod: mod_e'(modulation_i), power: power_dbm_i,
                          sync: sync_len_i, pay: payload_len_i, var_len: variable_mode_i,
                          crc: crc_on_i, node: node_filter_i});
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i)
      book.check_result('{ok: valid_res_o, bitrate: bitrate_word_o, fdev: fdev_word_o,
                          frf: frf_word_o, modul: modul_code_o, rx_bw: rx_bw_code_o,
                          pa: pa_code_o, pkt: pkt_config_o, sync: sync_code_o,
                          len: length_code_o});
  end

  function automatic setting_req_t make_req(longint unsigned carrier, longint unsigned rate,
                                            longint unsigned dev, longint unsigned bw,
                                            mod_e mod, int pwr, int sync, int pay,
                                            logic [2:0] flags);
    setting_req_t r;
    r.carrier = CARRIER_W'(carrier);
    r.rate    = RATE_W'(rate);
    r.dev     = DEV_W'(dev);
    r.bw      = BW_W'(bw);
    r.mod     = mod;
    r.power   = PWR_W'(pwr);
    r.sync    = SYNC_W'(sync);
    r.pay     = PAY_W'(pay);
    {r.var_len, r.crc, r.node} = flags;
    return r;
  endfunction

  // mostly well-formed requests, some with one field spoiled, some pure noise
  function automatic setting_req_t random_req();
    setting_req_t r;
    int kind;
    kind = $urandom_range(0, 99);
    r.carrier = CARRIER_W'($urandom);
    r.rate    = RATE_W'($urandom);
    r.dev     = DEV_W'($urandom);
    r.bw      = BW_W'($urandom);
    r.mod     = mod_e'(MOD_W'($urandom));
    r.power   = PWR_W'($urandom);
    r.sync    = SYNC_W'($urandom);
    r.pay     = PAY_W'($urandom);
    {r.var_len, r.crc, r.node} = 3'($urandom);
    if (kind < 80) begin
      r.carrier = CARRIER_W'($urandom_range(CARRIER_MIN, CARRIER_MAX));
      r.rate    = RATE_W'($urandom_range(1, RATE_MAX));
      if ($urandom_range(0, 1)) r.dev = DEV_W'($urandom_range(1, 300000));
      case ($urandom_range(0, 2))
        0: r.bw = BW_W'($urandom_range(1, 520000));
        1: r.bw = BW_W'($urandom_range(1, 20000));
        default: ;
      endcase
      r.mod   = mod_e'($urandom_range(MOD_FSK, MOD_OOK));
      r.power = PWR_W'(int'($urandom_range(0, PWR_MAX - PWR_MIN)) + PWR_MIN);
      r.sync  = SYNC_W'($urandom_range(0, MAX_SYNC_BYTES));
      if ($urandom_range(0, 9) == 0) begin
        r.pay = '0;
        {r.var_len, r.crc, r.node} = 3'b000;
      end else begin
        r.pay = PAY_W'($urandom_range(1, MAX_PAYLOAD));
      end
    end
    if (kind >= 65 && kind < 80) begin
      case ($urandom_range(0, 7))
        0: r.carrier = CARRIER_W'($urandom);
        1: r.rate    = RATE_W'($urandom_range(0, 1) ? 0 : $urandom);
        2: r.mod     = mod_e'($urandom_range(0, 1) ? MOD_NONE : $urandom_range(MOD_LORA, 7));
        3: r.power   = PWR_W'($urandom);
        4: r.sync    = SYNC_W'($urandom);
        5: r.pay     = PAY_W'($urandom);
        6: begin
          r.pay = '0;
          {r.var_len, r.crc, r.node} = 3'($urandom_range(1, 7));
        end
        default: r.bw = BW_W'($urandom);
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input setting_req_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i         <= 1'b1;
    carrier_hz_i    <= r.carrier;
    bit_rate_i      <= r.rate;
    deviation_i     <= r.dev;
    bandwidth_i     <= r.bw;
    modulation_i    <= r.mod;
    power_dbm_i     <= r.power;
    sync_len_i      <= r.sync;
    payload_len_i   <= r.pay;
    variable_mode_i <= r.var_len;
    crc_on_i        <= r.crc;
    node_filter_i   <= r.node;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_request(random_req());
  endtask

  initial begin
    book = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every modulation, range edges, special cases
    send_request(make_req(0, 0, 0, 0, MOD_NONE, 0, 0, 0, 3'b000));
    send_request(make_req(1073741823, 524287, 1048575, 1048575, MOD_INVALID, 31, 15, 255,
                          3'b111));
    for (int m = 0; m < 8; m++)
      send_request(make_req(868000000, 4800, 5000, 100000, mod_e'(m), 13, 2, 32, 3'b111));
    send_request(make_req(289999999, 9600, 20000, 50000, MOD_FSK, -32, 4, 16, 3'b010));
    send_request(make_req(290000000, 9600, 20000, 50000, MOD_GFSK, -18, 4, 16, 3'b010));
    send_request(make_req(1020000000, 300000, 20000, 50000, MOD_MSK, -19, 4, 16, 3'b010));
    send_request(make_req(1020000001, 300001, 20000, 50000, MOD_GMSK, 14, 4, 16, 3'b010));
    // slowest rate and widest deviation hit the word clamps
    send_request(make_req(433920000, 1, 1048575, 10000, MOD_FSK, 0, 8, 64, 3'b100));
    send_request(make_req(433920000, 0, 0, 10000, MOD_FSK, 0, 9, 65, 3'b100));
    // unlimited stream with a packet option set
    send_request(make_req(433920000, 4800, 5000, 10000, MOD_FSK, 0, 1, 0, 3'b100));
    send_request(make_req(433920000, 4800, 5000, 10000, MOD_FSK, 0, 1, 0, 3'b010));
    send_request(make_req(433920000, 4800, 5000, 10000, MOD_FSK, 0, 1, 0, 3'b001));
    send_request(make_req(433920000, 4800, 5000, 10000, MOD_FSK, 0, 1, 255, 3'b001));
    // exact candidate, too wide for every code, narrowest request
    send_request(make_req(915000000, 4800, 5000, 500000, MOD_FSK, 5, 3, 20, 3'b000));
    send_request(make_req(915000000, 4800, 5000, 500001, MOD_GFSK, 5, 3, 20, 3'b000));
    send_request(make_req(915000000, 4800, 5000, 1, MOD_OOK, 5, 3, 20, 3'b000));
    send_request(make_req(915000000, 4800, 5000, 250001, MOD_OOK, 5, 3, 20, 3'b000));

    send_random(200);

    // no idling on either side; receiver holds off so the pipeline backs up
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    hold_go      <= ~hold_go;
    send_random(150);

    tx_idle_pct  = IDLE_PCT;
    rx_stall_pct <= IDLE_PCT;
    send_random(176);

    valid_i <= 1'b0;
    while (book.words_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (book.mismatches == 0 && book.words_due.size() == 0) begin
      $display("PASS radio_setting_register_calc_unit");
    end else begin
      $display("FAIL radio_setting_register_calc_unit");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAIL radio_setting_register_calc_unit");
    $finish;
  end

endmodule
